>>> sv/boct_pkg.sv
`default_nettype none

package boct_pkg;

  // Width of the APB address; registers sit at byte addresses 0, 4, 8, 12 and 16.
  localparam int unsigned ADDR_BITS  = 5;
  localparam int unsigned LIMIT_BITS = 15;
  localparam int unsigned HOLD_BITS  = 16;

  // Register indexes, taken from the word address paddr[4:2].
  localparam logic [2:0] REG_DCH_CONT = 3'd0;
  localparam logic [2:0] REG_DCH_PEAK = 3'd1;
  localparam logic [2:0] REG_CHG_CONT = 3'd2;
  localparam logic [2:0] REG_CHG_PEAK = 3'd3;
  localparam logic [2:0] REG_HOLD     = 3'd4;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_DCH_CONT = 3'd1,
    KIND_DCH_PEAK = 3'd2,
    KIND_CHG_CONT = 3'd3,
    KIND_CHG_PEAK = 3'd4
  } trip_kind_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] dch_cont_limit;
    logic [LIMIT_BITS-1:0] dch_peak_limit;
    logic [LIMIT_BITS-1:0] chg_cont_limit;
    logic [LIMIT_BITS-1:0] chg_peak_limit;
    logic [HOLD_BITS-1:0]  peak_hold_time;
  } boct_cfg_t;

endpackage

`default_nettype wire

>>> sv/boct_cfg_regs.sv
`default_nettype none

module boct_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [boct_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output boct_pkg::boct_cfg_t            cfg
);
  import boct_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_BITS-1:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dch_cont_limit <= 15'd2000;
      cfg.dch_peak_limit <= 15'd1500;
      cfg.chg_cont_limit <= 15'd1000;
      cfg.chg_peak_limit <= 15'd800;
      cfg.peak_hold_time <= 16'd1000;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DCH_CONT: cfg.dch_cont_limit <= pwdata[LIMIT_BITS-1:0];
        REG_DCH_PEAK: cfg.dch_peak_limit <= pwdata[LIMIT_BITS-1:0];
        REG_CHG_CONT: cfg.chg_cont_limit <= pwdata[LIMIT_BITS-1:0];
        REG_CHG_PEAK: cfg.chg_peak_limit <= pwdata[LIMIT_BITS-1:0];
        REG_HOLD:     cfg.peak_hold_time <= pwdata[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (reg_index)
      REG_DCH_CONT: prdata = {17'd0, cfg.dch_cont_limit};
      REG_DCH_PEAK: prdata = {17'd0, cfg.dch_peak_limit};
      REG_CHG_CONT: prdata = {17'd0, cfg.chg_cont_limit};
      REG_CHG_PEAK: prdata = {17'd0, cfg.chg_peak_limit};
      REG_HOLD:     prdata = {16'd0, cfg.peak_hold_time};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/boct_eval.sv
`default_nettype none

module boct_eval #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  boct_pkg::boct_cfg_t    cfg,
  input  logic                   en,
  input  logic signed [15:0]     current_sample,
  input  logic [31:0]            now_ms,
  output boct_pkg::trip_kind_t   kind
);
  import boct_pkg::*;

  logic [TIME_BITS-1:0] hold_start_time;
  logic                 hold_armed;
  logic                 hold_is_charge;
  logic [TIME_BITS-1:0] hold_start_time_next;
  logic                 hold_armed_next;
  logic                 hold_is_charge_next;

  logic [63:0]          now_wide;
  logic [63:0]          hold_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 is_zero;
  logic                 is_chg;
  logic [15:0]          mag;
  logic [15:0]          cont_limit;
  logic [15:0]          peak_limit;
  logic                 running;

  assign now_wide  = {32'd0, now_ms};
  assign hold_wide = {48'd0, cfg.peak_hold_time};
  assign now_t     = now_wide[TIME_BITS-1:0];
  assign elapsed   = now_t - hold_start_time;

  assign is_zero = (current_sample == 16'sd0);
  assign is_chg  = current_sample[15];
  // Charge magnitude is the two's complement negation; the most negative
  // sample gives 0x8000, which is exactly 32768 in the unsigned view.
  assign mag        = is_chg ? (16'd0 - current_sample) : current_sample;
  assign cont_limit = {1'b0, is_chg ? cfg.chg_cont_limit : cfg.dch_cont_limit};
  assign peak_limit = {1'b0, is_chg ? cfg.chg_peak_limit : cfg.dch_peak_limit};
  // A direction change counts as a timer that is not running.
  assign running    = hold_armed && (hold_is_charge == is_chg);

  always_comb begin
    kind                 = KIND_NONE;
    hold_start_time_next = hold_start_time;
    hold_armed_next      = 1'b0;
    hold_is_charge_next  = hold_is_charge;
    priority if (is_zero) begin
      hold_armed_next = 1'b0;
    end else if (mag >= cont_limit) begin
      kind = is_chg ? KIND_CHG_CONT : KIND_DCH_CONT;
    end else if (mag >= peak_limit) begin
      hold_is_charge_next = is_chg;
      if (!running) begin
        hold_armed_next      = 1'b1;
        hold_start_time_next = now_t;
      end else if (elapsed > hold_wide[TIME_BITS-1:0]) begin
        kind = is_chg ? KIND_CHG_PEAK : KIND_DCH_PEAK;
      end else begin
        hold_armed_next = 1'b1;
      end
    end else begin
      hold_armed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_start_time <= '0;
      hold_armed      <= 1'b0;
      hold_is_charge  <= 1'b0;
    end else if (en) begin
      hold_start_time <= hold_start_time_next;
      hold_armed      <= hold_armed_next;
      hold_is_charge  <= hold_is_charge_next;
    end
  end

  a_peak_trip_disarms: assert property (@(posedge clk) disable iff (rst)
    en && (kind == KIND_DCH_PEAK || kind == KIND_CHG_PEAK) |=> !hold_armed)
    else $error("peak trip left the hold timer armed");

  a_cont_trip_keeps_dir: assert property (@(posedge clk) disable iff (rst)
    en && (kind == KIND_DCH_CONT || kind == KIND_CHG_CONT)
    |=> !hold_armed && $stable(hold_is_charge))
    else $error("continuous trip did not disarm or changed direction");

  a_zero_disarms: assert property (@(posedge clk) disable iff (rst)
    en && is_zero |=> !hold_armed)
    else $error("zero current left the hold timer armed");

endmodule

`default_nettype wire

>>> sv/bidirectional_overcurrent_trip_core.sv
`default_nettype none
// An accepted request is captured in the input register; its trip evaluation moves
// into the result register once that register is empty or is being drained.
// Throughput: one request per cycle unless the result stalls; compare is combinational.
// Reset (rst, synchronous, active high) empties both registers, disarms the
// hold timer and restores every limit register to its default value.

module bidirectional_overcurrent_trip_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // Sample channel.
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic signed [15:0]             current_sample,
  input  logic [31:0]                    now_ms,
  // Result channel.
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           trip,
  output logic [2:0]                     trip_kind,
  // APB configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [boct_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import boct_pkg::*;

  boct_cfg_t   cfg;
  trip_kind_t  eval_kind;

  // Input register: holds one accepted request until it is evaluated.
  logic               s1_valid;
  logic signed [15:0] s1_sample;
  logic [31:0]        s1_now;
  logic               advance;

  // The request in the input register is evaluated, and the hold timer state
  // updated, in the cycle that its result moves into the result register.
  // That happens whenever the result register is empty or is being drained,
  // so a stalled result holds the request behind it only until the result is
  // taken, and back-to-back requests stream through at one per cycle.
  assign advance      = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s1_sample <= current_sample;
      s1_now    <= now_ms;
    end
  end

  boct_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  boct_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .en             (advance),
    .current_sample (s1_sample),
    .now_ms         (s1_now),
    .kind           (eval_kind)
  );

  // Result register. It is cleared only when its result is taken and no
  // new result replaces it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trip      <= (eval_kind != KIND_NONE);
      trip_kind <= eval_kind;
    end
  end

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_now) && $stable(s1_sample))
    else $error("waiting request was lost or changed in the input register");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid && !s1_valid)
    else $error("registers not empty after reset");

endmodule

`default_nettype wire
